// ===== rtl/rhc_pkg.sv =====
// shared types and constants of the rgb to hsv converter
package rhc_pkg;

  localparam int CHAN_W   = 8;
  localparam int QUO_W    = 15;
  localparam int DVD_W    = CHAN_W + QUO_W;
  localparam int NUM_CELLS = QUO_W;

  localparam int LANE_HUE  = 0;
  localparam int LANE_SAT  = 1;
  localparam int NUM_LANES = 2;

  localparam logic [QUO_W-1:0] HUE_FULL = 15'd23040;
  localparam logic [QUO_W-1:0] PCT_FULL = 15'd25600;

  // hue arithmetic in 1/64 degree, signed wide enough for 23040 * 255
  localparam logic signed [24:0] HUE_SIXTH_S     = 25'sd3840;
  localparam logic signed [24:0] HUE_THIRD_S     = 25'sd7680;
  localparam logic signed [24:0] HUE_TWO_THIRD_S = 25'sd15360;
  localparam logic signed [24:0] HUE_FULL_S      = 25'sd23040;

  localparam logic [DVD_W-1:0]  PCT_MUL  = 23'd25600;

  // value = 100 * max + round(100 * max / 255), the fraction by reciprocal
  localparam logic [QUO_W-1:0]  VAL_STEP = 15'd100;
  localparam logic [QUO_W-1:0]  VAL_HALF = 15'd127;
  localparam logic [QUO_W-1:0]  VAL_ONE  = 15'd1;

  // one long division: partial remainder, divisor, and a word that
  // shifts dividend bits out at the top and quotient bits in at the bottom
  typedef struct packed {
    logic [CHAN_W-1:0] rem;
    logic [CHAN_W-1:0] dvsr;
    logic [QUO_W-1:0]  word;
  } rhc_lane_t;

  // hue and saturation lanes; the saturation divisor also carries max
  typedef struct packed {
    rhc_lane_t [NUM_LANES-1:0] lane;
    logic                      gray;
    logic                      black;
  } rhc_stage_t;

endpackage

// ===== rtl/rhc_ifs.sv =====
// pixel and hsv stream interfaces
interface rhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface rhc_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] hue_out;
  logic [14:0] saturation_out;
  logic [14:0] value_out;

  modport source (output valid, output hue_out, output saturation_out, output value_out,
                  input ready);
  modport sink (input valid, input hue_out, input saturation_out, input value_out,
                output ready);
endinterface

// ===== rtl/rhc_front.sv =====
// max/min/delta search and dividend setup for the division lanes
module rhc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rhc_pkg::rhc_stage_t stage_o
);
  import rhc_pkg::*;

  logic                    valid_r;
  logic                    valid_nxt;
  rhc_stage_t              stage_r;
  rhc_stage_t              stage_nxt;
  logic                    red_max;
  logic                    grn_max;
  logic [CHAN_W-1:0]       mx;
  logic [CHAN_W-1:0]       mn;
  logic [CHAN_W-1:0]       delta;
  logic signed [CHAN_W:0]  num_s;
  logic signed [24:0]      dl_s;
  logic signed [24:0]      t_s;
  logic [DVD_W-1:0]        dvd_hue;
  logic [DVD_W-1:0]        dvd_sat;

  assign ready_o   = !valid_r || ready_i;
  assign valid_nxt = ready_o ? valid_i : valid_r;

  always_comb begin
    red_max = (red_i >= green_i) && (red_i >= blue_i);
    grn_max = !red_max && (green_i >= blue_i);
    if (red_max) begin
      mx    = red_i;
      num_s = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (grn_max) begin
      mx    = green_i;
      num_s = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      mx    = blue_i;
      num_s = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    mn = red_i;
    if (green_i < mn) mn = green_i;
    if (blue_i < mn) mn = blue_i;
    delta = mx - mn;

    dl_s = $signed({17'b0, delta});
    t_s  = HUE_SIXTH_S * 25'(num_s);
    if (grn_max) begin
      t_s = t_s + HUE_THIRD_S * dl_s;
    end else if (!red_max) begin
      t_s = t_s + HUE_TWO_THIRD_S * dl_s;
    end
    // negative hue wraps once around the circle
    if (t_s < 0) begin
      t_s = t_s + HUE_FULL_S * dl_s;
    end
    dvd_hue = t_s[DVD_W-1:0];
    dvd_sat = PCT_MUL * {{QUO_W{1'b0}}, delta};

    // top dividend bits are below the divisor, so they seed the remainder
    stage_nxt.lane[LANE_HUE].rem  = dvd_hue[DVD_W-1:QUO_W];
    stage_nxt.lane[LANE_HUE].word = dvd_hue[QUO_W-1:0];
    stage_nxt.lane[LANE_HUE].dvsr = delta;
    stage_nxt.lane[LANE_SAT].rem  = dvd_sat[DVD_W-1:QUO_W];
    stage_nxt.lane[LANE_SAT].word = dvd_sat[QUO_W-1:0];
    stage_nxt.lane[LANE_SAT].dvsr = mx;
    stage_nxt.gray  = (delta == '0);
    stage_nxt.black = (mx == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      stage_r <= stage_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

  a_black_is_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && stage_r.black) |-> stage_r.gray)
    else $error("black pixel without zero delta");

endmodule

// ===== rtl/rhc_div_cell.sv =====
// one restoring division step on each of the two lanes
module rhc_div_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  rhc_pkg::rhc_stage_t stage_i,
  output logic                valid_o,
  input  logic                ready_i,
  output rhc_pkg::rhc_stage_t stage_o
);
  import rhc_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  rhc_stage_t  stage_r;
  rhc_stage_t  stage_nxt;
  logic [CHAN_W:0] acc;
  logic [CHAN_W:0] diff;
  logic            fits;

  assign ready_o   = !valid_r || ready_i;
  assign valid_nxt = ready_o ? valid_i : valid_r;

  always_comb begin
    acc       = '0;
    diff      = '0;
    fits      = 1'b0;
    stage_nxt = stage_i;
    for (int k = 0; k < NUM_LANES; k++) begin
      acc  = {stage_i.lane[k].rem, stage_i.lane[k].word[QUO_W-1]};
      diff = acc - {1'b0, stage_i.lane[k].dvsr};
      fits = (acc >= {1'b0, stage_i.lane[k].dvsr});
      stage_nxt.lane[k].rem  = fits ? diff[CHAN_W-1:0] : acc[CHAN_W-1:0];
      stage_nxt.lane[k].word = {stage_i.lane[k].word[QUO_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      stage_r <= stage_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule

// ===== rtl/rhc_round.sv =====
// round to nearest, apply gray/black/wrap cases, value from max, output register
module rhc_round (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  rhc_pkg::rhc_stage_t stage_i,
  output logic                valid_o,
  input  logic                ready_i,
  output logic [14:0]         hue_o,
  output logic [14:0]         sat_o,
  output logic [14:0]         val_o
);
  import rhc_pkg::*;

  logic             valid_r;
  logic             valid_nxt;
  logic [QUO_W-1:0] hue_r;
  logic [QUO_W-1:0] hue_nxt;
  logic [QUO_W-1:0] sat_r;
  logic [QUO_W-1:0] sat_nxt;
  logic [QUO_W-1:0] val_r;
  logic [QUO_W-1:0] val_nxt;
  logic [QUO_W-1:0] rnd [NUM_LANES];
  logic [QUO_W-1:0] val_lin;
  logic [QUO_W-1:0] val_x;
  logic [QUO_W-1:0] val_q;

  assign ready_o   = !valid_r || ready_i;
  assign valid_nxt = ready_o ? valid_i : valid_r;

  always_comb begin
    // round up when twice the remainder reaches the divisor
    for (int k = 0; k < NUM_LANES; k++) begin
      rnd[k] = stage_i.lane[k].word + QUO_W'({stage_i.lane[k].rem, 1'b0} >=
                                             {1'b0, stage_i.lane[k].dvsr});
    end
    if (stage_i.gray || rnd[LANE_HUE] == HUE_FULL) begin
      hue_nxt = '0;
    end else begin
      hue_nxt = rnd[LANE_HUE];
    end
    sat_nxt = stage_i.black ? '0 : rnd[LANE_SAT];

    // max rides along as the saturation divisor; x / 255 via (x + 1 + x/256) / 256
    val_lin = {{(QUO_W-CHAN_W){1'b0}}, stage_i.lane[LANE_SAT].dvsr} * VAL_STEP;
    val_x   = val_lin + VAL_HALF;
    val_q   = (val_x + VAL_ONE + (val_x >> CHAN_W)) >> CHAN_W;
    val_nxt = val_lin + val_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      hue_r <= hue_nxt;
      sat_r <= sat_nxt;
      val_r <= val_nxt;
    end
  end

  assign valid_o = valid_r;
  assign hue_o   = hue_r;
  assign sat_o   = sat_r;
  assign val_o   = val_r;

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (hue_r < HUE_FULL))
    else $error("hue word past full circle");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (sat_r <= PCT_FULL))
    else $error("saturation word above full scale");

  a_val_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (val_r <= PCT_FULL))
    else $error("value word above full scale");

endmodule

// ===== rtl/rgb_to_hsv_converter.sv =====
// rgb to hsv converter top level: front stage, division cell chain, rounding stage
//
// in_px carries one 8-bit rgb pixel per word; out_hsv returns hue in 1/64
// degree and saturation and value in 1/256 percent, one word per pixel, in
// order. Both channels use valid/ready; a word moves when both are high.
// The block is a pipeline of 17 registered stages: the front stage finds
// max, min and delta and sets up two dividends, a chain of 15 identical
// cells each resolves one quotient bit for hue and saturation at once, and
// a last stage rounds to nearest, works out value from the max channel and
// holds the output word.
// Throughput is one pixel per cycle while out_hsv.ready stays high, set
// by the one-bit-per-cell division chain.
// Each stage takes a new word when it is empty or its successor takes its
// word, so bubbles close up: with out_hsv.ready low the block still accepts
// pixels until all 17 stages are full, then in_px.ready drops.
// Synchronous reset clears every stage valid bit; the data registers are
// not reset, and the block accepts pixels in the first cycle after reset.
module rgb_to_hsv_converter (
  input  logic      clk,
  input  logic      rst_n,
  rhc_in_if.sink    in_px,
  rhc_out_if.source out_hsv
);
  import rhc_pkg::*;

  rhc_stage_t chain_d   [NUM_CELLS+1];
  logic       chain_v   [NUM_CELLS+1];
  logic       chain_rdy [NUM_CELLS+1];

  rhc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (in_px.valid),
    .ready_o (in_px.ready),
    .red_i   (in_px.red_in),
    .green_i (in_px.green_in),
    .blue_i  (in_px.blue_in),
    .valid_o (chain_v[0]),
    .ready_i (chain_rdy[0]),
    .stage_o (chain_d[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (chain_v[i]),
      .ready_o (chain_rdy[i]),
      .stage_i (chain_d[i]),
      .valid_o (chain_v[i+1]),
      .ready_i (chain_rdy[i+1]),
      .stage_o (chain_d[i+1])
    );
  end

  rhc_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (chain_v[NUM_CELLS]),
    .ready_o (chain_rdy[NUM_CELLS]),
    .stage_i (chain_d[NUM_CELLS]),
    .valid_o (out_hsv.valid),
    .ready_i (out_hsv.ready),
    .hue_o   (out_hsv.hue_out),
    .sat_o   (out_hsv.saturation_out),
    .val_o   (out_hsv.value_out)
  );

endmodule
